>>> sv/gsdc_pkg.sv
// Shared constants for the grid stream disk cover block.
`default_nettype none
package gsdc_pkg;

  // Grid geometry
  localparam int unsigned GRID_COLS = 64;
  localparam int unsigned GRID_ROWS = 64;
  localparam int unsigned CELL_COUNT = GRID_COLS * GRID_ROWS;

  // Field and datapath widths
  localparam int unsigned COORD_W = 16;
  localparam int unsigned COL_W   = $clog2(GRID_COLS);
  localparam int unsigned ROW_W   = $clog2(GRID_ROWS);
  localparam int unsigned IDX_W   = $clog2(CELL_COUNT);
  localparam int unsigned VH_W    = (COL_W > ROW_W) ? COL_W : ROW_W;
  localparam int unsigned PROD_W  = COORD_W + VH_W;
  localparam int unsigned DBL_W   = PROD_W + 3;
  localparam int unsigned R2_W    = COORD_W + 1;
  localparam int unsigned SQ_W    = 2 * R2_W;
  localparam int unsigned SUM_W   = SQ_W + 1;

  // Configuration port
  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;
  localparam logic REG_RADIUS = 1'b0;
  localparam logic REG_SIDE   = 1'b1;
  localparam logic [COORD_W-1:0] RADIUS_RST = 16'd320;
  localparam logic [COORD_W-1:0] SIDE_RST   = 16'd453;

endpackage
`default_nettype wire

>>> sv/gsdc_if.sv
// Valid/ready stream interfaces for points in and cover results out.
`default_nettype none
interface gsdc_point_if;
  logic        valid;
  logic        ready;
  logic [15:0] point_x;
  logic [15:0] point_y;
  modport source (output valid, point_x, point_y, input ready);
  modport sink   (input valid, point_x, point_y, output ready);
endinterface

interface gsdc_result_if;
  logic        valid;
  logic        ready;
  logic        disk_placed;
  logic [15:0] center_x;
  logic [15:0] center_y;
  logic        out_of_grid;
  modport source (output valid, disk_placed, center_x, center_y, out_of_grid, input ready);
  modport sink   (input valid, disk_placed, center_x, center_y, out_of_grid, output ready);
endinterface
`default_nettype wire

>>> sv/grid_stream_disk_cover.sv
// Top level: streaming unit-disk cover over a cell bitmap held in block RAM.
//
// After reset the block sweeps the 4096-entry cell bitmap to zero, one entry
// per cycle, and takes no point during the sweep (register writes are taken
// throughout). Each point is then handled alone: it is accepted, x and y are
// divided bit-serially by the cell side, cell origins and then margins are
// worked out, then the bitmap is read for the own cell and for each side
// neighbour tried, with a distance check (difference, square, compare) where
// needed, and the result is handed over.
// A point whose cell lies off the grid finishes right after the divide, and a
// zero cell side skips the divide altogether. The divider and the single
// bitmap read port set the rate.
// The result register lets the next point be accepted while a result waits.
`default_nettype none
module grid_stream_disk_cover import gsdc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  gsdc_point_if.sink        point_i,
  gsdc_result_if.source     result_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  typedef enum logic [3:0] {
    ST_CLR, ST_IDLE, ST_DIV, ST_MUL, ST_PREP, ST_RD, ST_EVAL, ST_DX, ST_SQ, ST_CMP, ST_FIN
  } state_e;

  typedef enum logic [2:0] {NB_OWN, NB_RIGHT, NB_LEFT, NB_ABOVE, NB_BELOW} nb_e;

  localparam int unsigned CNT_W = (IDX_W > 4) ? IDX_W : 4;

  state_e state_q;
  nb_e    k_q;
  logic [CNT_W-1:0] cnt_q;

  logic [COORD_W-1:0] radius_q, side_q;
  logic [COORD_W-1:0] px_q, py_q, qx_q, qy_q, remx_q, remy_q;
  logic [COL_W-1:0]   v_q;
  logic [ROW_W-1:0]   h_q;
  logic [IDX_W-1:0]   own_idx_q;
  logic [PROD_W-1:0]  ox_q, oy_q;
  logic signed [DBL_W-1:0] s3_q;
  logic signed [DBL_W-1:0] xlo_q, xhi_q, ylo_q, yhi_q;
  logic signed [DBL_W-1:0] xa_q, xb_q, xc_q, ya_q, yb_q, yc_q;
  logic               nb_ok_q, far_q, place_q, oob_q;
  logic [R2_W-1:0]    adx_q, ady_q;
  logic [SQ_W-1:0]    sqx_q, sqy_q, rsq_q;

  logic               out_valid_q, out_placed_q, out_oob_q;
  logic [COORD_W-1:0] out_cx_q, out_cy_q;

  // Bitmap memory
  logic              mem_q [CELL_COUNT];
  logic              rd_q;
  logic              we;
  logic [IDX_W-1:0]  waddr;
  logic [IDX_W-1:0]  raddr;
  logic              wdata;

  // Config writes and reads
  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_SIDE) ? APB_DW'(side_q) : APB_DW'(radius_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RADIUS_RST;
      side_q   <= SIDE_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_RADIUS) radius_q <= pwdata[COORD_W-1:0];
      else                        side_q   <= pwdata[COORD_W-1:0];
    end
  end

  // Divider steps for x and y
  logic [COORD_W:0] shx, shy;
  logic             gex, gey;
  assign shx = {remx_q, qx_q[COORD_W-1]};
  assign shy = {remy_q, qy_q[COORD_W-1]};
  assign gex = shx >= {1'b0, side_q};
  assign gey = shy >= {1'b0, side_q};

  // Doubled point, radius and cell origins, and the side
  logic signed [DBL_W-1:0] x2, y2, sw, r2w, ox2, oy2;
  assign x2  = signed'(DBL_W'({px_q, 1'b0}));
  assign y2  = signed'(DBL_W'({py_q, 1'b0}));
  assign sw  = signed'(DBL_W'(side_q));
  assign r2w = signed'(DBL_W'({radius_q, 1'b0}));
  assign ox2 = signed'(DBL_W'({ox_q, 1'b0}));
  assign oy2 = signed'(DBL_W'({oy_q, 1'b0}));

  // Per-neighbour selection: grid check, index, margin and doubled centre
  logic              nb_in;
  logic [IDX_W-1:0]  nb_idx;
  logic              margin;
  logic signed [DBL_W-1:0] cx2, cy2;
  logic              inner;
  nb_e               k_next;

  assign inner = (x2 >= xlo_q) && (x2 <= xhi_q) && (y2 >= ylo_q) && (y2 <= yhi_q);

  always_comb begin
    nb_in  = 1'b1;
    nb_idx = own_idx_q;
    margin = 1'b0;
    cx2    = xb_q;
    cy2    = yb_q;
    k_next = NB_BELOW;
    case (k_q)
      NB_OWN: begin
        k_next = NB_RIGHT;
      end
      NB_RIGHT: begin
        nb_in  = (32'(v_q) + 32'd1) < GRID_COLS;
        nb_idx = own_idx_q + IDX_W'(1);
        margin = x2 >= xhi_q;
        cx2    = xc_q;
        k_next = NB_LEFT;
      end
      NB_LEFT: begin
        nb_in  = v_q != '0;
        nb_idx = own_idx_q - IDX_W'(1);
        margin = x2 <= xlo_q;
        cx2    = xa_q;
        k_next = NB_ABOVE;
      end
      NB_ABOVE: begin
        nb_in  = (32'(h_q) + 32'd1) < GRID_ROWS;
        nb_idx = own_idx_q + IDX_W'(GRID_COLS);
        margin = y2 >= yhi_q;
        cy2    = yc_q;
        k_next = NB_BELOW;
      end
      NB_BELOW: begin
        nb_in  = h_q != '0;
        nb_idx = own_idx_q - IDX_W'(GRID_COLS);
        margin = y2 <= ylo_q;
        cy2    = ya_q;
      end
      default: begin
        nb_in = 1'b0;
      end
    endcase
  end

  // Distance terms
  logic signed [DBL_W-1:0] dx, dy, adx, ady;
  assign dx  = x2 - cx2;
  assign dy  = y2 - cy2;
  assign adx = (dx < 0) ? -dx : dx;
  assign ady = (dy < 0) ? -dy : dy;

  logic [SUM_W-1:0] dist_sum;
  assign dist_sum = SUM_W'(sqx_q) + SUM_W'(sqy_q);

  // Result hand-over
  logic out_free, fin_fire;
  assign out_free = !out_valid_q || result_o.ready;
  assign fin_fire = (state_q == ST_FIN) && out_free;

  // Saturated centres
  logic [PROD_W:0] cen_x, cen_y;
  assign cen_x = (PROD_W+1)'(ox_q) + (PROD_W+1)'(side_q >> 1);
  assign cen_y = (PROD_W+1)'(oy_q) + (PROD_W+1)'(side_q >> 1);

  logic marked;
  assign marked = rd_q && nb_ok_q;

  assign point_i.ready = (state_q == ST_IDLE);

  // Main sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLR;
      k_q          <= NB_OWN;
      cnt_q        <= '0;
      out_valid_q  <= 1'b0;
      out_placed_q <= 1'b0;
      out_oob_q    <= 1'b0;
      out_cx_q     <= '0;
      out_cy_q     <= '0;
      place_q      <= 1'b0;
      oob_q        <= 1'b0;
    end else begin
      if (result_o.ready && !fin_fire) out_valid_q <= 1'b0;
      case (state_q)
        ST_CLR: begin
          cnt_q <= cnt_q + CNT_W'(1);
          if (cnt_q == CNT_W'(CELL_COUNT - 1)) state_q <= ST_IDLE;
        end
        ST_IDLE: begin
          if (point_i.valid) begin
            px_q    <= point_i.point_x;
            py_q    <= point_i.point_y;
            qx_q    <= point_i.point_x;
            qy_q    <= point_i.point_y;
            remx_q  <= '0;
            remy_q  <= '0;
            cnt_q   <= '0;
            place_q <= 1'b0;
            oob_q   <= (side_q == '0);
            state_q <= (side_q == '0) ? ST_FIN : ST_DIV;
          end
        end
        ST_DIV: begin
          remx_q <= gex ? COORD_W'(shx - {1'b0, side_q}) : shx[COORD_W-1:0];
          remy_q <= gey ? COORD_W'(shy - {1'b0, side_q}) : shy[COORD_W-1:0];
          qx_q   <= {qx_q[COORD_W-2:0], gex};
          qy_q   <= {qy_q[COORD_W-2:0], gey};
          cnt_q  <= cnt_q + CNT_W'(1);
          if (cnt_q == CNT_W'(COORD_W - 1)) state_q <= ST_MUL;
        end
        ST_MUL: begin
          if (32'(qx_q) >= GRID_COLS || 32'(qy_q) >= GRID_ROWS) begin
            oob_q   <= 1'b1;
            state_q <= ST_FIN;
          end else begin
            v_q       <= qx_q[COL_W-1:0];
            h_q       <= qy_q[ROW_W-1:0];
            own_idx_q <= IDX_W'(32'(qy_q) * GRID_COLS + 32'(qx_q));
            ox_q      <= PROD_W'(qx_q[COL_W-1:0]) * PROD_W'(side_q);
            oy_q      <= PROD_W'(qy_q[ROW_W-1:0]) * PROD_W'(side_q);
            s3_q      <= signed'(DBL_W'({side_q, 1'b0})) + signed'(DBL_W'(side_q));
            state_q   <= ST_PREP;
          end
        end
        ST_PREP: begin
          xlo_q   <= ox2 + r2w - sw;
          xhi_q   <= ox2 + s3_q - r2w;
          ylo_q   <= oy2 + r2w - sw;
          yhi_q   <= oy2 + s3_q - r2w;
          xa_q    <= ox2 - sw;
          xb_q    <= ox2 + sw;
          xc_q    <= ox2 + s3_q;
          ya_q    <= oy2 - sw;
          yb_q    <= oy2 + sw;
          yc_q    <= oy2 + s3_q;
          k_q     <= NB_OWN;
          state_q <= ST_RD;
        end
        ST_RD: begin
          nb_ok_q <= nb_in;
          state_q <= ST_EVAL;
        end
        ST_EVAL: begin
          if (k_q == NB_OWN) begin
            if (marked || inner) begin
              place_q <= !marked;
              state_q <= ST_FIN;
            end else begin
              k_q     <= k_next;
              state_q <= ST_RD;
            end
          end else if (marked && margin) begin
            state_q <= ST_DX;
          end else if (k_q == NB_BELOW) begin
            place_q <= 1'b1;
            state_q <= ST_FIN;
          end else begin
            k_q     <= k_next;
            state_q <= ST_RD;
          end
        end
        ST_DX: begin
          far_q   <= (adx > r2w) || (ady > r2w);
          adx_q   <= adx[R2_W-1:0];
          ady_q   <= ady[R2_W-1:0];
          state_q <= ST_SQ;
        end
        ST_SQ: begin
          sqx_q   <= adx_q * adx_q;
          sqy_q   <= ady_q * ady_q;
          rsq_q   <= SQ_W'({radius_q, 1'b0}) * SQ_W'({radius_q, 1'b0});
          state_q <= ST_CMP;
        end
        ST_CMP: begin
          if (!far_q && dist_sum <= SUM_W'(rsq_q)) begin
            place_q <= 1'b0;
            state_q <= ST_FIN;
          end else if (k_q == NB_BELOW) begin
            place_q <= 1'b1;
            state_q <= ST_FIN;
          end else begin
            k_q     <= k_next;
            state_q <= ST_RD;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_placed_q <= place_q && !oob_q;
            out_oob_q    <= oob_q;
            out_cx_q     <= (place_q && !oob_q) ?
                            ((cen_x > (PROD_W+1)'(16'hFFFF)) ? 16'hFFFF : cen_x[COORD_W-1:0])
                            : '0;
            out_cy_q     <= (place_q && !oob_q) ?
                            ((cen_y > (PROD_W+1)'(16'hFFFF)) ? 16'hFFFF : cen_y[COORD_W-1:0])
                            : '0;
            state_q      <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Bitmap port control
  assign we    = (state_q == ST_CLR) || (fin_fire && place_q && !oob_q);
  assign waddr = (state_q == ST_CLR) ? cnt_q[IDX_W-1:0] : own_idx_q;
  assign wdata = (state_q != ST_CLR);
  assign raddr = nb_idx;

  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wdata;
    rd_q <= mem_q[raddr];
  end

  assign result_o.valid       = out_valid_q;
  assign result_o.disk_placed = out_placed_q;
  assign result_o.center_x    = out_cx_q;
  assign result_o.center_y    = out_cy_q;
  assign result_o.out_of_grid = out_oob_q;

endmodule
`default_nettype wire

>>> sv/gsdc_checker.sv
// Port-level assertions for the disk cover block, bound to the top level.
`default_nettype none
module gsdc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        disk_placed_i,
  input logic [15:0] center_x_i,
  input logic [15:0] center_y_i,
  input logic        out_of_grid_i
);

  // A held result keeps its centre
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(center_x_i) && $stable(center_y_i))
    else $error("result changed while stalled");

  // Off-grid points never place a disk
  a_oob: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_of_grid_i |-> !disk_placed_i)
    else $error("off-grid point placed a disk");

  // No disk, no centre
  a_zero_centre: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !disk_placed_i |-> center_x_i == 16'd0 && center_y_i == 16'd0)
    else $error("centre given without a disk");

  // One point at a time
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("second point taken while busy");

endmodule

bind grid_stream_disk_cover gsdc_checker u_gsdc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (point_i.valid),
  .in_ready_i   (point_i.ready),
  .out_valid_i  (result_o.valid),
  .out_ready_i  (result_o.ready),
  .disk_placed_i(result_o.disk_placed),
  .center_x_i   (result_o.center_x),
  .center_y_i   (result_o.center_y),
  .out_of_grid_i(result_o.out_of_grid)
);
`default_nettype wire
